// ===== rtl/core/rsrc_pkg.sv =====
`timescale 1ns / 1ps

package rsrc_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int BLOCK_BYTES = 4096;
  localparam int AMT_W       = 13;
  localparam int STEP_W      = SLOT_W + 1;

  typedef enum logic [1:0] {
    MODE_RESERVE = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_CLAIM   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_DONE         = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE      = 2'd1;
  localparam logic [1:0] STATUS_NO_COMMITTED = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [15:0] write_amount;
    logic [15:0] read_capacity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       granted_slot;
    logic [AMT_W-1:0] stored_amount;
    logic [AMT_W-1:0] copy_length;
  } out_item_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] nxt;
    nxt = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    return nxt;
  endfunction

  // clamp a byte count to the block size
  function automatic logic [AMT_W-1:0] sat_block(input logic [15:0] a);
    logic [AMT_W-1:0] r;
    r = (32'(a) < BLOCK_BYTES) ? AMT_W'(a) : AMT_W'(BLOCK_BYTES);
    return r;
  endfunction

endpackage

// ===== rtl/core/ring_slot_reserve_commit_top.sv =====
`timescale 1ns / 1ps
// order: reserve, failed claim and an out-of-range slot go from idle straight to the done state,
// a successful claim first reads the amount ram in the read state, and commit and release with a
// valid slot first sweep the cursor over the done slots, one per cycle, at most 16, then reach done
// flow: one request at a time, the next accepted once the result leaves the control fsm
// reset: synchronous active-low rst_n clears cursors, marks and valids; amounts are not cleared

module ring_slot_reserve_commit_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsrc_pkg::out_item_t out_data
);

  logic                          res_valid;
  logic                          res_ready;
  rsrc_pkg::out_item_t           res_data;
  logic                          ram_wr_en;
  logic [rsrc_pkg::SLOT_W-1:0]   ram_wr_addr;
  logic [rsrc_pkg::AMT_W-1:0]    ram_wr_data;
  logic [rsrc_pkg::SLOT_W-1:0]   ram_rd_addr;
  logic [rsrc_pkg::AMT_W-1:0]    ram_rd_data;

  logic                out_valid_r, out_valid_nxt;
  rsrc_pkg::out_item_t out_data_r;

  rsrc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  rsrc_amount_ram #(
    .DEPTH (rsrc_pkg::SLOT_COUNT),
    .WIDTH (rsrc_pkg::AMT_W)
  ) u_amount_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register takes a result when empty or draining; the fsm waits in done while a held result is stalled
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/rsrc_amount_ram.sv =====
`timescale 1ns / 1ps

module rsrc_amount_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 13,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/rsrc_ctrl.sv =====
`timescale 1ns / 1ps

module rsrc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rsrc_pkg::in_item_t           in_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output rsrc_pkg::out_item_t          res_data,
  output logic                         ram_wr_en,
  output logic [rsrc_pkg::SLOT_W-1:0]  ram_wr_addr,
  output logic [rsrc_pkg::AMT_W-1:0]   ram_wr_data,
  output logic [rsrc_pkg::SLOT_W-1:0]  ram_rd_addr,
  input  logic [rsrc_pkg::AMT_W-1:0]   ram_rd_data
);

  rsrc_pkg::ctrl_state_t state_r, state_nxt;

  logic [rsrc_pkg::SLOT_W-1:0]     reserve_r, reserve_nxt;
  logic [rsrc_pkg::SLOT_W-1:0]     commit_r, commit_nxt;
  logic [rsrc_pkg::SLOT_W-1:0]     claim_r, claim_nxt;
  logic [rsrc_pkg::SLOT_W-1:0]     release_r, release_nxt;
  logic [rsrc_pkg::SLOT_COUNT-1:0] wmarks_r, wmarks_nxt;
  logic [rsrc_pkg::SLOT_COUNT-1:0] rmarks_r, rmarks_nxt;
  logic [rsrc_pkg::STEP_W-1:0]     steps_r, steps_nxt;
  logic                            sweep_rel_r, sweep_rel_nxt;
  rsrc_pkg::out_item_t             res_r, res_nxt;

  logic                        slot_ok;
  logic [rsrc_pkg::SLOT_W-1:0] slot_idx;
  logic                        ring_full;
  logic                        ring_empty;
  logic                        sweep_go;

  assign slot_ok    = 32'(in_data.slot) < rsrc_pkg::SLOT_COUNT;
  assign slot_idx   = rsrc_pkg::SLOT_W'(in_data.slot);
  assign ring_full  = rsrc_pkg::next_slot(reserve_r) == release_r;
  assign ring_empty = claim_r == commit_r;

  // one slot per cycle, at most a full lap
  assign sweep_go = (steps_r < rsrc_pkg::STEP_W'(rsrc_pkg::SLOT_COUNT)) &&
                    (sweep_rel_r ? rmarks_r[release_r] : wmarks_r[commit_r]);

  assign in_stall    = state_r != rsrc_pkg::S_IDLE;
  assign res_valid   = state_r == rsrc_pkg::S_DONE;
  assign res_data    = res_r;
  assign ram_rd_addr = claim_r;
  assign ram_wr_addr = slot_idx;
  assign ram_wr_data = rsrc_pkg::sat_block(in_data.write_amount);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsrc_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.mode)
            rsrc_pkg::MODE_COMMIT,
            rsrc_pkg::MODE_RELEASE: state_nxt = slot_ok ? rsrc_pkg::S_SWEEP : rsrc_pkg::S_DONE;
            rsrc_pkg::MODE_CLAIM:   state_nxt = ring_empty ? rsrc_pkg::S_DONE : rsrc_pkg::S_READ;
            default:                state_nxt = rsrc_pkg::S_DONE;
          endcase
        end
      end
      rsrc_pkg::S_READ:  state_nxt = rsrc_pkg::S_DONE;
      rsrc_pkg::S_SWEEP: state_nxt = sweep_go ? rsrc_pkg::S_SWEEP : rsrc_pkg::S_DONE;
      rsrc_pkg::S_DONE:  state_nxt = res_ready ? rsrc_pkg::S_IDLE : rsrc_pkg::S_DONE;
      default:           state_nxt = rsrc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    reserve_nxt   = reserve_r;
    commit_nxt    = commit_r;
    claim_nxt     = claim_r;
    release_nxt   = release_r;
    wmarks_nxt    = wmarks_r;
    rmarks_nxt    = rmarks_r;
    steps_nxt     = steps_r;
    sweep_rel_nxt = sweep_rel_r;
    res_nxt       = res_r;
    ram_wr_en     = 1'b0;
    case (state_r)
      rsrc_pkg::S_IDLE: begin
        if (in_valid) begin
          res_nxt       = '0;
          steps_nxt     = '0;
          sweep_rel_nxt = in_data.mode == rsrc_pkg::MODE_RELEASE;
          case (in_data.mode)
            rsrc_pkg::MODE_RESERVE: begin
              if (ring_full) begin
                res_nxt.status = rsrc_pkg::STATUS_NO_FREE;
              end else begin
                res_nxt.granted_slot = 4'(reserve_r);
                reserve_nxt          = rsrc_pkg::next_slot(reserve_r);
              end
            end
            rsrc_pkg::MODE_COMMIT: begin
              if (slot_ok) begin
                ram_wr_en            = 1'b1;
                wmarks_nxt[slot_idx] = 1'b1;
              end
            end
            rsrc_pkg::MODE_CLAIM: begin
              if (ring_empty) begin
                res_nxt.status = rsrc_pkg::STATUS_NO_COMMITTED;
              end else begin
                // stored amount arrives from the ram next cycle
                res_nxt.granted_slot = 4'(claim_r);
                res_nxt.copy_length  = rsrc_pkg::sat_block(in_data.read_capacity);
                claim_nxt            = rsrc_pkg::next_slot(claim_r);
              end
            end
            rsrc_pkg::MODE_RELEASE: begin
              if (slot_ok) begin
                rmarks_nxt[slot_idx] = 1'b1;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      rsrc_pkg::S_READ: begin
        res_nxt.stored_amount = ram_rd_data;
      end
      rsrc_pkg::S_SWEEP: begin
        if (sweep_go) begin
          steps_nxt = steps_r + 1'b1;
          if (sweep_rel_r) begin
            rmarks_nxt[release_r] = 1'b0;
            release_nxt           = rsrc_pkg::next_slot(release_r);
          end else begin
            wmarks_nxt[commit_r] = 1'b0;
            commit_nxt           = rsrc_pkg::next_slot(commit_r);
          end
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rsrc_pkg::S_IDLE;
      reserve_r <= '0;
      commit_r  <= '0;
      claim_r   <= '0;
      release_r <= '0;
      wmarks_r  <= '0;
      rmarks_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      reserve_r <= reserve_nxt;
      commit_r  <= commit_nxt;
      claim_r   <= claim_nxt;
      release_r <= release_nxt;
      wmarks_r  <= wmarks_nxt;
      rmarks_r  <= rmarks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r     <= steps_nxt;
    sweep_rel_r <= sweep_rel_nxt;
    res_r       <= res_nxt;
  end

endmodule

// ===== rtl/core/rsrc_checker.sv =====
`timescale 1ns / 1ps

module rsrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rsrc_pkg::out_item_t out_data
);

  // held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in progress");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == rsrc_pkg::STATUS_DONE ||
                   out_data.status == rsrc_pkg::STATUS_NO_FREE ||
                   out_data.status == rsrc_pkg::STATUS_NO_COMMITTED))
    else $error("illegal status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == rsrc_pkg::STATUS_NO_FREE ||
                  out_data.status == rsrc_pkg::STATUS_NO_COMMITTED)
    |-> out_data.granted_slot == '0 && out_data.stored_amount == '0 &&
        out_data.copy_length == '0)
    else $error("failed request returned nonzero fields");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after accept");

endmodule

bind ring_slot_reserve_commit_top rsrc_checker u_rsrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
